### rtl/core/ffha_pkg.sv
package ffha_pkg;

    localparam int unsigned WINDOW_BYTES_DEF = 67108864;
    localparam int unsigned MAX_BLOCKS_DEF   = 64;
    localparam int unsigned HEADER_BYTES     = 16;
    localparam int unsigned GRAIN            = 16;
    localparam int unsigned OFS_W            = 26;
    localparam int unsigned SIZE_W           = 27;
    localparam int unsigned ADDR_W           = 32;
    localparam logic [31:0] HEAP_BASE_RESET  = 32'hF000_0000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_BAD_FREE = 2'd2,
        ST_NULL     = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Shift command for one cycle; only the cells selected by the shift mask act on it.
    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_RIGHT = 2'd1,
        SH_LEFT  = 2'd2
    } shift_t;

    typedef enum logic [2:0] {
        FS_IDLE   = 3'd0,
        FS_SCAN   = 3'd1,
        FS_APPLY  = 3'd2,
        FS_MERGE2 = 3'd3,
        FS_OUT    = 3'd4,
        FS_SPLIT  = 3'd5
    } fsm_t;

    // Contents of one cell.
    typedef struct packed {
        logic              valid;
        logic              taken;
        logic [OFS_W-1:0]  offset;
        logic [OFS_W-1:0]  payload;
    } entry_t;

    // Command from the sequencer to the row of cells.
    typedef struct packed {
        shift_t            shift;
        logic              wr_en;
        entry_t            wr_data;
        logic [OFS_W-1:0]  size;
        logic [OFS_W-1:0]  match_off;
    } cell_cmd_t;

endpackage

### rtl/core/ffha_cell.sv
module ffha_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                init_head,
    input  logic [25:0]         init_payload,
    input  ffha_pkg::cell_cmd_t cmd,
    input  logic                wr_sel,
    input  ffha_pkg::entry_t    left_in,
    input  ffha_pkg::entry_t    right_in,
    output ffha_pkg::entry_t    data_out,
    output logic                fit,
    output logic                hit
);

    ffha_pkg::entry_t ent_reg;
    ffha_pkg::entry_t ent_next;

    // Each cell compares its own block against the broadcast request.
    assign fit = ent_reg.valid && !ent_reg.taken && (ent_reg.payload >= cmd.size);
    assign hit = ent_reg.valid && (ent_reg.offset == cmd.match_off);
    assign data_out = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        case (cmd.shift)
            ffha_pkg::SH_RIGHT: ent_next = left_in;
            ffha_pkg::SH_LEFT:  ent_next = right_in;
            default:            ent_next = ent_reg;
        endcase
        if (cmd.wr_en && wr_sel) begin
            ent_next = cmd.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid   <= init_head;
            ent_reg.taken   <= 1'b0;
            ent_reg.offset  <= '0;
            ent_reg.payload <= init_head ? init_payload : '0;
        end else begin
            ent_reg <= ent_next;
        end
    end

endmodule

### rtl/core/ffha_chain.sv
module ffha_chain #(
    parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned WINDOW_BYTES = ffha_pkg::WINDOW_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ffha_pkg::cell_cmd_t     cmd,
    input  logic [MAX_BLOCKS-1:0]   wr_sel,
    input  logic [MAX_BLOCKS-1:0]   shift_mask,
    output ffha_pkg::entry_t        cells [MAX_BLOCKS],
    output logic [MAX_BLOCKS-1:0]   fit_vec,
    output logic [MAX_BLOCKS-1:0]   hit_vec
);

    localparam logic [25:0] INIT_PAYLOAD = 26'(WINDOW_BYTES - ffha_pkg::HEADER_BYTES);

    ffha_pkg::entry_t empty_ent;
    assign empty_ent = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffha_pkg::entry_t    lft;
        ffha_pkg::entry_t    rgt;
        ffha_pkg::cell_cmd_t ccmd;

        // A cell below the affected index keeps its contents on a shift.
        always_comb begin
            ccmd = cmd;
            if (!shift_mask[g]) begin
                ccmd.shift = ffha_pkg::SH_NONE;
            end
        end

        if (g == 0) begin : g_l
            assign lft = empty_ent;
        end else begin : g_l
            assign lft = cells[g-1];
        end
        if (g == MAX_BLOCKS - 1) begin : g_r
            assign rgt = empty_ent;
        end else begin : g_r
            assign rgt = cells[g+1];
        end

        ffha_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .init_head   (g == 0),
            .init_payload(INIT_PAYLOAD),
            .cmd         (ccmd),
            .wr_sel      (wr_sel[g]),
            .left_in     (lft),
            .right_in    (rgt),
            .data_out    (cells[g]),
            .fit         (fit_vec[g]),
            .hit         (hit_vec[g])
        );
    end

endmodule

### rtl/core/first_fit_heap_allocator.sv
// A request passes through the scan, apply and output states, with an extra split or
// merge state for an allocate that splits a block or a free that merges with the previous block.
// One request at a time: a new request is accepted only once the block is idle and
// the previous result has been taken.
// Reset (aresetn, synchronous, active low) leaves one free block over the whole
// window, heap_base at 0xF0000000 and no bytes in use.
module first_fit_heap_allocator #(
    parameter int unsigned WINDOW_BYTES = ffha_pkg::WINDOW_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [26:0] s_request_size,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_payload_address,
    output logic [1:0]  m_status,
    output logic [26:0] m_bytes_in_use,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

    ffha_pkg::fsm_t    state_reg, state_next;

    // Configuration register; writes only land while the block is idle.
    logic [31:0] heap_base_reg;
    assign cfg_ready = (state_reg == ffha_pkg::FS_IDLE);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= ffha_pkg::HEAP_BASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            heap_base_reg <= cfg_data;
        end
    end

    // Captured request.
    logic              op_reg;
    logic [25:0]       size_reg;
    logic [25:0]       off_reg;
    logic              zero_reg;
    logic              null_reg;
    logic              big_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [25:0]       inuse_reg, inuse_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic              merge_prev_reg, merge_prev_next;

    logic              m_valid_reg, m_valid_next;
    logic [31:0]       out_addr_reg, out_addr_next;
    ffha_pkg::status_t out_stat_reg, out_stat_next;

    // Row of cells.
    ffha_pkg::cell_cmd_t     cmd;
    logic [MAX_BLOCKS-1:0]   wr_sel;
    logic [MAX_BLOCKS-1:0]   shift_mask;
    ffha_pkg::entry_t        cells [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]   fit_vec;
    logic [MAX_BLOCKS-1:0]   hit_vec;

    ffha_chain #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .wr_sel    (wr_sel),
        .shift_mask(shift_mask),
        .cells     (cells),
        .fit_vec   (fit_vec),
        .hit_vec   (hit_vec)
    );

    // Priority pick over the match vector: the lowest set cell wins. Allocate
    // looks for a fit, free for an offset hit (offsets are unique).
    logic [MAX_BLOCKS-1:0] pick_vec;
    logic [IDX_W-1:0]      pick_idx;
    logic                  pick_any;
    always_comb begin
        pick_vec = (op_reg == ffha_pkg::OP_FREE) ? hit_vec : fit_vec;
        pick_idx = '0;
        pick_any = 1'b0;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
            if (pick_vec[k]) begin
                pick_idx = IDX_W'(k);
                pick_any = 1'b1;
            end
        end
    end

    // Registered view of the picked cell and its neighbors.
    ffha_pkg::entry_t cur_reg, nxt_reg, prv_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ffha_pkg::FS_SCAN) begin
            cur_reg <= cells[pick_idx];
            nxt_reg <= (32'(pick_idx) + 1 < MAX_BLOCKS) ?
                       cells[IDX_W'(32'(pick_idx) + 1)] : '0;
            prv_reg <= (pick_idx != '0) ? cells[pick_idx - 1'b1] : '0;
        end else if (state_reg == ffha_pkg::FS_APPLY && op_reg == ffha_pkg::OP_FREE) begin
            // In a free the current payload always grows by a header and the next block's payload.
            cur_reg.payload <= cur_reg.payload + 26'(ffha_pkg::HEADER_BYTES) +
                               nxt_reg.payload;
        end
    end

    // The rounded size keeps two bits above the window so that huge requests
    // never wrap into a small one.
    logic [27:0] rounded;
    assign rounded = (28'(s_request_size) + 28'(ffha_pkg::GRAIN - 1)) &
                     ~28'(ffha_pkg::GRAIN - 1);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            size_reg <= rounded[25:0];
            big_reg  <= |rounded[27:26];
            zero_reg <= (s_request_size == '0);
            null_reg <= (s_address == '0);
            off_reg  <= 26'(s_address - heap_base_reg - 32'(ffha_pkg::HEADER_BYTES));
        end
    end

    // The free offset may lie outside 26 bits; keep that as a bad address flag.
    logic off_out_reg;
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            off_out_reg <= |((s_address - heap_base_reg -
                              32'(ffha_pkg::HEADER_BYTES)) >> ffha_pkg::OFS_W);
        end
    end

    logic [26:0] split_need;
    logic        can_split;
    assign split_need = 27'(size_reg) + 27'(ffha_pkg::HEADER_BYTES + 16);
    assign can_split  = (27'(cur_reg.payload) >= split_need) &&
                        (32'(count_reg) < MAX_BLOCKS);

    assign s_ready = (state_reg == ffha_pkg::FS_IDLE) && !m_valid_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        inuse_next      = inuse_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        merge_prev_next = merge_prev_reg;
        m_valid_next    = m_valid_reg;
        out_addr_next   = out_addr_reg;
        out_stat_next   = out_stat_reg;
        cmd             = '0;
        cmd.size        = size_reg;
        cmd.match_off   = off_reg;
        wr_sel          = '0;
        shift_mask      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ffha_pkg::FS_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ffha_pkg::FS_SCAN;
                end
            end
            ffha_pkg::FS_SCAN: begin
                // The size is only meaningful for an allocate.
                idx_next   = pick_idx;
                found_next = pick_any && (op_reg == ffha_pkg::OP_FREE || !big_reg);
                state_next = ffha_pkg::FS_APPLY;
            end
            ffha_pkg::FS_APPLY: begin
                state_next    = ffha_pkg::FS_OUT;
                out_addr_next = '0;
                if (op_reg == ffha_pkg::OP_ALLOC) begin
                    if (zero_reg || !found_reg) begin
                        out_stat_next = ffha_pkg::ST_NO_FIT;
                    end else begin
                        out_stat_next = ffha_pkg::ST_OK;
                        out_addr_next = heap_base_reg + 32'(cur_reg.offset) +
                                        32'(ffha_pkg::HEADER_BYTES);
                        cmd.wr_en          = 1'b1;
                        cmd.wr_data        = cur_reg;
                        cmd.wr_data.taken  = 1'b1;
                        if (can_split) begin
                            cmd.wr_data.payload = size_reg;
                            inuse_next = inuse_reg + size_reg;
                            // Open a hole after idx; the remainder fills it next cycle.
                            cmd.shift = ffha_pkg::SH_RIGHT;
                            for (int k = 0; k < MAX_BLOCKS; k++) begin
                                shift_mask[k] = (32'(k) > 32'(idx_reg));
                            end
                            wr_sel[idx_reg] = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = ffha_pkg::FS_SPLIT;
                        end else begin
                            inuse_next = inuse_reg + cur_reg.payload;
                            wr_sel[idx_reg] = 1'b1;
                        end
                    end
                end else begin
                    if (null_reg) begin
                        out_stat_next = ffha_pkg::ST_NULL;
                    end else if (!found_reg || off_out_reg || !cur_reg.taken) begin
                        out_stat_next = ffha_pkg::ST_BAD_FREE;
                    end else begin
                        out_stat_next  = ffha_pkg::ST_OK;
                        inuse_next     = inuse_reg - cur_reg.payload;
                        cmd.wr_en      = 1'b1;
                        cmd.wr_data    = cur_reg;
                        cmd.wr_data.taken = 1'b0;
                        wr_sel[idx_reg] = 1'b1;
                        merge_prev_next = (idx_reg != '0) && !prv_reg.taken;
                        if (nxt_reg.valid && !nxt_reg.taken) begin
                            cmd.wr_data.payload = cur_reg.payload +
                                26'(ffha_pkg::HEADER_BYTES) + nxt_reg.payload;
                            cmd.shift = ffha_pkg::SH_LEFT;
                            for (int k = 0; k < MAX_BLOCKS; k++) begin
                                shift_mask[k] = (32'(k) > 32'(idx_reg));
                            end
                            count_next = count_reg - 1'b1;
                        end
                        if ((idx_reg != '0) && !prv_reg.taken) begin
                            state_next = ffha_pkg::FS_MERGE2;
                        end
                    end
                end
            end
            ffha_pkg::FS_SPLIT: begin
                // The free remainder follows the allocated block and its header.
                cmd.wr_en           = 1'b1;
                cmd.wr_data.valid   = 1'b1;
                cmd.wr_data.taken   = 1'b0;
                cmd.wr_data.offset  = cur_reg.offset + 26'(ffha_pkg::HEADER_BYTES) +
                                      size_reg;
                cmd.wr_data.payload = cur_reg.payload - size_reg -
                                      26'(ffha_pkg::HEADER_BYTES);
                if (32'(idx_reg) + 1 < MAX_BLOCKS) begin
                    wr_sel[IDX_W'(32'(idx_reg) + 1)] = 1'b1;
                end
                state_next = ffha_pkg::FS_OUT;
            end
            ffha_pkg::FS_MERGE2: begin
                // Fold the freed block into the previous one. cur_reg holds the payload grown by
                // the next block; without a merge with the next block that growth is taken back here.
                cmd.wr_en   = 1'b1;
                cmd.wr_data = prv_reg;
                cmd.wr_data.payload = prv_reg.payload + 26'(ffha_pkg::HEADER_BYTES) +
                    ((nxt_reg.valid && !nxt_reg.taken) ? cur_reg.payload
                                                        : cur_reg.payload -
                                                          26'(ffha_pkg::HEADER_BYTES) -
                                                          nxt_reg.payload);
                wr_sel[idx_reg - 1'b1] = 1'b1;
                cmd.shift = ffha_pkg::SH_LEFT;
                for (int k = 0; k < MAX_BLOCKS; k++) begin
                    shift_mask[k] = (32'(k) >= 32'(idx_reg));
                end
                count_next = count_next - 1'b1;
                state_next = ffha_pkg::FS_OUT;
            end
            ffha_pkg::FS_OUT: begin
                m_valid_next = 1'b1;
                state_next   = ffha_pkg::FS_IDLE;
            end
            default: state_next = ffha_pkg::FS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ffha_pkg::FS_IDLE;
            count_reg      <= CNT_W'(1);
            inuse_reg      <= '0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            merge_prev_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            inuse_reg      <= inuse_next;
            m_valid_reg    <= m_valid_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            merge_prev_reg <= merge_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_payload_address = out_addr_reg;
    assign m_status          = out_stat_reg;
    assign m_bytes_in_use    = 27'(inuse_reg);

endmodule

### rtl/core/ffha_checker.sv
module ffha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_payload_address,
    input logic [1:0]  m_status
);

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_address))
        else $error("result changed while stalled");

    // Only a successful allocate returns a nonzero address.
    a_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ffha_pkg::ST_OK |-> m_payload_address == 32'd0)
        else $error("address on failed request");

    // A request accepted is not followed by another before its result.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_payload_address(m_payload_address),
    .m_status         (m_status)
);

### tb/sv/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;

    localparam int unsigned WIN   = 67108864;
    localparam int unsigned NBLK  = 64;
    localparam int          WATCHDOG_LIMIT = 20000;

    // One pending request for the driver.
    typedef struct packed {
        ffha_pkg::op_t op;
        logic [26:0]   size;
        logic [31:0]   addr;
    } alloc_req_t;

    // One predicted result.
    typedef struct packed {
        logic [31:0]       addr;
        ffha_pkg::status_t status;
        logic [26:0]       in_use;
    } alloc_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic [26:0] s_request_size = '0;
    logic [31:0] s_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_payload_address;
    logic [1:0]  m_status;
    logic [26:0] m_bytes_in_use;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    first_fit_heap_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_request_size(s_request_size), .s_address(s_address),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_payload_address(m_payload_address), .m_status(m_status),
        .m_bytes_in_use(m_bytes_in_use),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Model of the block table: offsets and payloads relative to heap_base.
    logic [31:0] mdl_base;
    logic [25:0] mdl_off [NBLK];
    logic [25:0] mdl_pay [NBLK];
    logic        mdl_taken [NBLK];
    int          mdl_count;
    logic [25:0] mdl_in_use;

    // A shadow table used only to know which addresses are live ahead of time.
    logic [31:0] sh_base;
    logic [25:0] sh_off [NBLK];
    logic [25:0] sh_pay [NBLK];
    logic        sh_taken [NBLK];
    int          sh_count;
    logic [25:0] sh_in_use;

    alloc_req_t  pending_reqs[$];
    alloc_res_t  expected_results[$];
    logic [31:0] live_addrs[$];   // payload addresses handed out, some of them already freed
    int          errors = 0;
    int          n_allocs = 0, n_frees = 0;
    bit          stim_done = 1'b0;
    bit          hold_sender = 1'b0;

    task automatic table_reset();
        mdl_base = ffha_pkg::HEAP_BASE_RESET;
        mdl_count = 1;
        mdl_off[0] = '0;
        mdl_pay[0] = 26'(WIN - ffha_pkg::HEADER_BYTES);
        mdl_taken[0] = 1'b0;
        mdl_in_use = '0;
    endtask

    function automatic void drop_entry(input int k);
        for (int j = k; j + 1 < mdl_count; j++) begin
            mdl_off[j] = mdl_off[j+1];
            mdl_pay[j] = mdl_pay[j+1];
            mdl_taken[j] = mdl_taken[j+1];
        end
        mdl_count--;
    endfunction

    // Applies one request to the table and returns the result it causes.
    function automatic alloc_res_t heap_step(input alloc_req_t r);
        alloc_res_t res;
        logic [31:0] rounded;
        logic [31:0] off;
        int i;
        res.addr = '0;
        res.status = ffha_pkg::ST_OK;
        if (r.op == ffha_pkg::OP_ALLOC) begin
            res.status = ffha_pkg::ST_NO_FIT;
            rounded = ({5'd0, r.size} + 32'd15) & ~32'd15;
            if (r.size != 0) begin
                for (i = 0; i < mdl_count; i++) begin
                    if (!mdl_taken[i] && {6'd0, mdl_pay[i]} >= rounded) begin
                        if ({6'd0, mdl_pay[i]} >= rounded + 32 && mdl_count < NBLK) begin
                            for (int j = mdl_count; j > i + 1; j--) begin
                                mdl_off[j] = mdl_off[j-1];
                                mdl_pay[j] = mdl_pay[j-1];
                                mdl_taken[j] = mdl_taken[j-1];
                            end
                            mdl_off[i+1] = 26'(mdl_off[i] + ffha_pkg::HEADER_BYTES + rounded);
                            mdl_pay[i+1] = 26'(mdl_pay[i] - rounded - ffha_pkg::HEADER_BYTES);
                            mdl_taken[i+1] = 1'b0;
                            mdl_pay[i] = 26'(rounded);
                            mdl_count++;
                        end
                        mdl_taken[i] = 1'b1;
                        mdl_in_use = mdl_in_use + mdl_pay[i];
                        res.addr = mdl_base + {6'd0, mdl_off[i]} + ffha_pkg::HEADER_BYTES;
                        res.status = ffha_pkg::ST_OK;
                        break;
                    end
                end
            end
        end else if (r.addr == 0) begin
            res.status = ffha_pkg::ST_NULL;
        end else begin
            off = r.addr - mdl_base - ffha_pkg::HEADER_BYTES;
            for (i = 0; i < mdl_count; i++)
                if ({6'd0, mdl_off[i]} == off) break;
            if (i >= mdl_count || !mdl_taken[i]) begin
                res.status = ffha_pkg::ST_BAD_FREE;
            end else begin
                mdl_taken[i] = 1'b0;
                mdl_in_use = mdl_in_use - mdl_pay[i];
                if (i + 1 < mdl_count && !mdl_taken[i+1]) begin
                    mdl_pay[i] = mdl_pay[i] + 26'(ffha_pkg::HEADER_BYTES) + mdl_pay[i+1];
                    drop_entry(i + 1);
                end
                if (i > 0 && !mdl_taken[i-1]) begin
                    mdl_pay[i-1] = mdl_pay[i-1] + 26'(ffha_pkg::HEADER_BYTES) + mdl_pay[i];
                    drop_entry(i);
                end
            end
        end
        res.in_use = {1'b0, mdl_in_use};
        return res;
    endfunction

    // Driver: bursts of random length with random gaps. A new request is loaded
    // in the same step that the previous one is taken, so valid is never
    // lowered and raised within one step.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && !hold_sender && gap_left == 0) begin
                    alloc_req_t r;
                    r = pending_reqs.pop_front();
                    expected_results.push_back(heap_step(r));
                    s_valid <= 1'b1;
                    s_operation <= r.op;
                    s_request_size <= r.size;
                    s_address <= r.addr;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                    end
                    burst_left--;
                    if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
                        gap_left = $urandom_range(1, 15);
                    end
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // Monitor: the receiver stalls on a slowly changing pattern, including
    // stretches with no stall at all.
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: addr %h status %0d",
                           m_payload_address, m_status);
                    errors++;
                end else begin
                    alloc_res_t e;
                    e = expected_results.pop_front();
                    if (m_payload_address !== e.addr) begin
                        $error("payload_address expected %h actual %h", e.addr,
                               m_payload_address);
                        errors++;
                    end
                    if (m_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_status);
                        errors++;
                    end
                    if (m_bytes_in_use !== e.in_use) begin
                        $error("bytes_in_use expected %0d actual %0d", e.in_use,
                               m_bytes_in_use);
                        errors++;
                    end
                end
            end
            if (stall_cnt == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_cnt = $urandom_range(20, 200);
            end
            stall_cnt--;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: cycles with no accepted request, result or configuration write.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else if (pending_reqs.size() != 0 || expected_results.size() != 0
                     || !stim_done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic alloc_req_t mk_alloc(input logic [26:0] sz);
        alloc_req_t r;
        r.op = ffha_pkg::OP_ALLOC;
        r.size = sz;
        r.addr = $urandom();
        return r;
    endfunction

    function automatic alloc_req_t mk_free(input logic [31:0] a);
        alloc_req_t r;
        r.op = ffha_pkg::OP_FREE;
        r.size = 27'($urandom());
        r.addr = a;
        return r;
    endfunction

    // Waits until the driver has sent everything and all results have arrived,
    // then lets the block settle.
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Writes heap_base while the block is idle. Live addresses follow the window.
    task automatic set_base(input logic [31:0] b);
        logic [31:0] old;
        old = mdl_base;
        cfg_valid <= 1'b1;
        cfg_data <= b;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mdl_base = b;
        foreach (live_addrs[k]) live_addrs[k] = live_addrs[k] - old + b;
    endtask

    // Queues a request for the driver.
    task automatic push_req(input alloc_req_t r);
        pending_reqs.push_back(r);
    endtask

    task automatic sync_shadow();
        sh_base = mdl_base; sh_off = mdl_off; sh_pay = mdl_pay; sh_taken = mdl_taken;
        sh_count = mdl_count; sh_in_use = mdl_in_use;
    endtask

    // The real prediction happens in the driver; here the shadow copy mirrors
    // it so live addresses are known when the stimulus is built.
    task automatic track_alloc(input alloc_req_t r);
        alloc_res_t res;
        logic [31:0] b_save;
        logic [25:0] o_save [NBLK];
        logic [25:0] p_save [NBLK];
        logic        t_save [NBLK];
        int          c_save;
        logic [25:0] u_save;
        b_save = mdl_base; o_save = mdl_off; p_save = mdl_pay; t_save = mdl_taken;
        c_save = mdl_count; u_save = mdl_in_use;
        mdl_base = sh_base; mdl_off = sh_off; mdl_pay = sh_pay; mdl_taken = sh_taken;
        mdl_count = sh_count; mdl_in_use = sh_in_use;
        res = heap_step(r);
        sh_off = mdl_off; sh_pay = mdl_pay; sh_taken = mdl_taken;
        sh_count = mdl_count; sh_in_use = mdl_in_use;
        mdl_base = b_save; mdl_off = o_save; mdl_pay = p_save; mdl_taken = t_save;
        mdl_count = c_save; mdl_in_use = u_save;
        if (r.op == ffha_pkg::OP_ALLOC && res.status == ffha_pkg::ST_OK && res.addr != 0)
            live_addrs.push_back(res.addr);
    endtask

    // Random phase: sizes mostly small so the table fills and splits often,
    // frees mostly target live blocks, with some null and bogus addresses.
    task automatic random_phase(input int n);
        alloc_req_t r;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                case ($urandom_range(0, 9))
                    0: r = mk_alloc(27'($urandom()));
                    1: r = mk_alloc(27'($urandom_range(0, 1 << 22)));
                    2: r = mk_alloc('0);
                    default: r = mk_alloc(27'($urandom_range(1, 600)));
                endcase
                n_allocs++;
            end else if (pick < 90 && live_addrs.size() != 0) begin
                int idx;
                idx = $urandom_range(0, live_addrs.size() - 1);
                r = mk_free(live_addrs[idx]);
                if ($urandom_range(0, 9) != 0) live_addrs.delete(idx);
                n_frees++;
            end else begin
                r = mk_free(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom());
                n_frees++;
            end
            push_req(r);
            // Predict locally to learn the addresses that allocations hand out.
            track_alloc(r);
        end
    endtask

    initial begin
        table_reset();
        sync_shadow();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: zero size, largest sizes, an exact whole-window fit,
        // null free, double free, out-of-window free and merges both ways.
        push_req(mk_alloc('0));
        push_req(mk_alloc(27'd67108864));
        push_req(mk_alloc(27'h7FF_FFFF));
        push_req(mk_alloc(27'(WIN - ffha_pkg::HEADER_BYTES)));
        track_alloc(pending_reqs[0]); track_alloc(pending_reqs[1]);
        track_alloc(pending_reqs[2]); track_alloc(pending_reqs[3]);
        push_req(mk_free(live_addrs[0])); track_alloc(pending_reqs[4]);
        push_req(mk_free(live_addrs[0])); track_alloc(pending_reqs[5]);
        live_addrs.delete();
        push_req(mk_free(32'd0)); track_alloc(pending_reqs[6]);
        push_req(mk_free(32'h0000_1000)); track_alloc(pending_reqs[7]);
        for (int k = 0; k < 4; k++) begin
            push_req(mk_alloc(27'(1 + 16 * k))); track_alloc(pending_reqs[$]);
        end
        // Free blocks two, four, three and one: no merge, next, both sides, next.
        push_req(mk_free(live_addrs[1])); track_alloc(pending_reqs[$]);
        push_req(mk_free(live_addrs[3])); track_alloc(pending_reqs[$]);
        push_req(mk_free(live_addrs[2])); track_alloc(pending_reqs[$]);
        push_req(mk_free(live_addrs[0])); track_alloc(pending_reqs[$]);
        live_addrs.delete();
        // Fill the table to its limit so the whole block is given unsplit.
        for (int k = 0; k < NBLK + 2; k++) begin
            push_req(mk_alloc(27'd32)); track_alloc(pending_reqs[$]);
        end
        drain();

        // Random phases under several window bases, the extremes among them.
        // Before each, the sender holds off until every result has come.
        for (int ph = 0; ph < 5; ph++) begin
            hold_sender = 1'b1;
            drain();
            case (ph)
                0: set_base(32'h0000_0000);
                1: set_base(32'hFFFF_FFF0);
                2: set_base(32'hFFFF_FFFF);
                3: set_base($urandom());
                default: set_base(ffha_pkg::HEAP_BASE_RESET);
            endcase
            sync_shadow();
            hold_sender = 1'b0;
            random_phase(165);
            drain();
        end
        stim_done = 1'b1;
        repeat (20) @(posedge aclk);

        $display("Covered %0d allocates and %0d frees over five window bases,",
                 n_allocs, n_frees);
        $display("including table overflow, merges, null and bogus frees.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
